/* hdl/cid_pkg.sv */
// Shared types and codes for the compact instruction decoder.
`default_nettype none
package cid_pkg;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [5:0] TYPE_UNKNOWN  = 6'd0;
  localparam logic [5:0] TYPE_LSL_IMM  = 6'd1;
  localparam logic [5:0] TYPE_ADD_REG  = 6'd4;
  localparam logic [5:0] TYPE_ADD_IMM3 = 6'd6;
  localparam logic [5:0] TYPE_SUB_IMM3 = 6'd7;
  localparam logic [5:0] TYPE_MOV_IMM8 = 6'd8;
  localparam logic [5:0] TYPE_SUB_IMM8 = 6'd11;
  localparam logic [5:0] TYPE_ALU_BASE = 6'd12;
  localparam logic [5:0] TYPE_ADD_HI   = 6'd28;
  localparam logic [5:0] TYPE_BX       = 6'd31;
  localparam logic [5:0] TYPE_BLX      = 6'd32;
  localparam logic [5:0] TYPE_LDR_PC   = 6'd33;
  localparam logic [5:0] TYPE_LDST_REG = 6'd34;
  localparam logic [5:0] TYPE_STR_IMM  = 6'd42;
  localparam logic [5:0] TYPE_STRH_IMM = 6'd46;
  localparam logic [5:0] TYPE_STR_SP   = 6'd48;
  localparam logic [5:0] TYPE_ADR_PC   = 6'd50;
  localparam logic [5:0] TYPE_ADR_SP   = 6'd51;
  localparam logic [5:0] TYPE_PUSH     = 6'd52;
  localparam logic [5:0] TYPE_POP      = 6'd53;
  localparam logic [5:0] TYPE_ADD_SP   = 6'd54;
  localparam logic [5:0] TYPE_STMIA    = 6'd56;
  localparam logic [5:0] TYPE_SVC      = 6'd58;
  localparam logic [5:0] TYPE_BCOND    = 6'd59;
  localparam logic [5:0] TYPE_B        = 6'd60;
  localparam logic [5:0] TYPE_BL       = 6'd61;
  localparam logic [5:0] TYPE_BKPT     = 6'd62;
  localparam logic [5:0] TYPE_HINT     = 6'd63;

  localparam logic [4:0] REG_NONE = 5'd16;
  localparam logic [4:0] REG_SP   = 5'd13;
  localparam logic [4:0] REG_PC   = 5'd15;

  localparam logic [3:0] COND_AL    = 4'd14;
  localparam logic [3:0] COND_NV    = 4'd15;
  localparam logic [3:0] SUB_ADD    = 4'd1;
  localparam logic [3:0] SUB_SUB    = 4'd2;
  localparam logic [3:0] SUB_BL     = 4'd1;

  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_BYTE = 2'd1;
  localparam logic [1:0] SIZE_HALF = 2'd2;

  typedef struct packed {
    logic [1:0]  access_size;
    logic        is_load;
    logic [15:0] register_list;
    logic [3:0]  sub_op;
    logic [4:0]  shift_count;
    logic        set_flags;
    logic [3:0]  condition;
    logic [23:0] immediate;
    logic [4:0]  second_reg;
    logic [4:0]  base_reg;
    logic [4:0]  dest_reg;
    logic [5:0]  inst_type;
  } dec_t;

endpackage
`default_nettype wire

/* hdl/compact_instruction_decoder_top.sv */
// Compact instruction decoder: input register, single decode stage, output register.
// One instruction is taken per cycle unless the result register is stalled; its decoded
// fields are captured first by the input register and then by the result
// register behind one decode stage. out_tready feeds in_tready combinationally, so a
// stalled result register lets one more item wait in the input register before the
// input stalls.
// A 32-bit pair that is not a branch-with-link decodes as unknown with default fields.
`default_nettype none
module compact_instruction_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // instr_word[31:0]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // inst_type[5:0], dest_reg[10:6], base_reg[15:11], second_reg[20:16],
  // immediate[44:21], condition[48:45], set_flags[49], shift_count[54:50],
  // sub_op[58:55], register_list[74:59], is_load[75], access_size[77:76], zero[79:78]
  output logic [79:0]      out_tdata
);

  logic                       in_vld_r;
  logic                       in_vld_nxt;
  logic [31:0]                in_word_r;
  logic                       in_kind_r;
  logic                       out_vld_r;
  cid_pkg::dec_t              out_dec_r;
  cid_pkg::dec_t              dec_nxt;
  logic                       advance;
  logic                       in_xfer;

  logic [15:0] h;
  logic [15:0] b;
  logic [4:0]  top5;
  logic [3:0]  top4;
  logic [2:0]  op3;
  logic        ld;
  logic        s;

  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_word_r <= in_tdata;
      in_kind_r <= in_tuser;
    end
    if (advance) begin
      out_dec_r <= dec_nxt;
    end
  end

  assign h    = in_word_r[15:0];
  assign b    = in_word_r[31:16];
  assign top5 = h[15:11];
  assign top4 = h[15:12];
  assign op3  = h[11:9];
  assign ld   = h[11];
  assign s    = h[10];

  always_comb begin
    dec_nxt               = '0;
    dec_nxt.inst_type     = cid_pkg::TYPE_UNKNOWN;
    dec_nxt.dest_reg      = cid_pkg::REG_NONE;
    dec_nxt.base_reg      = cid_pkg::REG_NONE;
    dec_nxt.second_reg    = cid_pkg::REG_NONE;
    if (in_kind_r) begin
      if (h[15:11] == 5'b11110 && b[15:14] == 2'b11 && b[12]) begin
        dec_nxt.inst_type = cid_pkg::TYPE_BL;
        dec_nxt.condition = cid_pkg::COND_AL;
        dec_nxt.sub_op    = cid_pkg::SUB_BL;
        dec_nxt.immediate = {s, ~(b[13] ^ s), ~(b[11] ^ s), h[9:0], b[10:0]};
      end
    end else if (top5 inside {[5'd0:5'd2]}) begin
      dec_nxt.dest_reg     = {2'b0, h[2:0]};
      dec_nxt.second_reg   = {2'b0, h[5:3]};
      dec_nxt.shift_count  = h[10:6];
      dec_nxt.inst_type    = cid_pkg::TYPE_LSL_IMM + {4'b0, top5[1:0]};
    end else if (top5 == 5'd3) begin
      dec_nxt.dest_reg  = {2'b0, h[2:0]};
      dec_nxt.base_reg  = {2'b0, h[5:3]};
      if (h[10]) begin
        dec_nxt.immediate = {21'b0, h[8:6]};
      end else begin
        dec_nxt.second_reg = {2'b0, h[8:6]};
      end
      dec_nxt.sub_op    = h[9] ? cid_pkg::SUB_SUB : cid_pkg::SUB_ADD;
      dec_nxt.set_flags = 1'b1;
      dec_nxt.inst_type = cid_pkg::TYPE_ADD_REG + {4'b0, h[10], h[9]};
    end else if (top4 inside {4'd2, 4'd3}) begin
      dec_nxt.dest_reg  = {2'b0, h[10:8]};
      dec_nxt.base_reg  = {2'b0, h[10:8]};
      dec_nxt.immediate = {16'b0, h[7:0]};
      dec_nxt.sub_op    = {2'b0, h[12:11]};
      dec_nxt.set_flags = 1'b1;
      dec_nxt.inst_type = cid_pkg::TYPE_MOV_IMM8 + {4'b0, h[12:11]};
    end else if (h[15:10] == 6'b010000) begin
      dec_nxt.dest_reg   = {2'b0, h[2:0]};
      dec_nxt.base_reg   = {2'b0, h[2:0]};
      dec_nxt.second_reg = {2'b0, h[5:3]};
      dec_nxt.sub_op     = h[9:6];
      dec_nxt.inst_type  = cid_pkg::TYPE_ALU_BASE + {2'b0, h[9:6]};
    end else if (h[15:10] == 6'b010001) begin
      dec_nxt.dest_reg   = {1'b0, h[7], h[2:0]};
      dec_nxt.second_reg = {1'b0, h[6], h[5:3]};
      dec_nxt.sub_op     = {2'b0, h[9:8]};
      dec_nxt.condition  = cid_pkg::COND_AL;
      if (h[9:8] != 2'd3) begin
        dec_nxt.inst_type = cid_pkg::TYPE_ADD_HI + {4'b0, h[9:8]};
      end else begin
        dec_nxt.inst_type = h[7] ? cid_pkg::TYPE_BLX : cid_pkg::TYPE_BX;
      end
    end else if (top5 == 5'd9) begin
      dec_nxt.dest_reg  = {2'b0, h[10:8]};
      dec_nxt.immediate = {14'b0, h[7:0], 2'b0};
      dec_nxt.base_reg  = cid_pkg::REG_PC;
      dec_nxt.is_load   = 1'b1;
      dec_nxt.inst_type = cid_pkg::TYPE_LDR_PC;
    end else if (top4 == 4'd5) begin
      dec_nxt.dest_reg   = {2'b0, h[2:0]};
      dec_nxt.base_reg   = {2'b0, h[5:3]};
      dec_nxt.second_reg = {2'b0, h[8:6]};
      dec_nxt.is_load    = (op3 >= 3'd3);
      case (op3)
        3'd1, 3'd5, 3'd7: dec_nxt.access_size = cid_pkg::SIZE_HALF;
        3'd2, 3'd3, 3'd6: dec_nxt.access_size = cid_pkg::SIZE_BYTE;
        default:          dec_nxt.access_size = cid_pkg::SIZE_WORD;
      endcase
      case (op3)
        3'd3:    dec_nxt.sub_op = 4'd1;
        3'd5:    dec_nxt.sub_op = 4'd2;
        3'd7:    dec_nxt.sub_op = 4'd3;
        default: dec_nxt.sub_op = 4'd0;
      endcase
      dec_nxt.inst_type = cid_pkg::TYPE_LDST_REG + {3'b0, op3};
    end else if (top4 inside {4'd6, 4'd7}) begin
      dec_nxt.dest_reg  = {2'b0, h[2:0]};
      dec_nxt.base_reg  = {2'b0, h[5:3]};
      dec_nxt.immediate = h[12] ? {19'b0, h[10:6]} : {17'b0, h[10:6], 2'b0};
      dec_nxt.is_load   = ld;
      dec_nxt.access_size = h[12] ? cid_pkg::SIZE_BYTE : cid_pkg::SIZE_WORD;
      dec_nxt.inst_type = cid_pkg::TYPE_STR_IMM + {4'b0, h[12], ld};
    end else if (top4 == 4'd8) begin
      dec_nxt.dest_reg    = {2'b0, h[2:0]};
      dec_nxt.base_reg    = {2'b0, h[5:3]};
      dec_nxt.immediate   = {18'b0, h[10:6], 1'b0};
      dec_nxt.is_load     = ld;
      dec_nxt.access_size = cid_pkg::SIZE_HALF;
      dec_nxt.inst_type   = cid_pkg::TYPE_STRH_IMM + {5'b0, ld};
    end else if (top4 == 4'd9) begin
      dec_nxt.dest_reg  = {2'b0, h[10:8]};
      dec_nxt.immediate = {14'b0, h[7:0], 2'b0};
      dec_nxt.base_reg  = cid_pkg::REG_SP;
      dec_nxt.is_load   = ld;
      dec_nxt.inst_type = cid_pkg::TYPE_STR_SP + {5'b0, ld};
    end else if (top4 == 4'd10) begin
      dec_nxt.dest_reg  = {2'b0, h[10:8]};
      dec_nxt.immediate = {14'b0, h[7:0], 2'b0};
      dec_nxt.base_reg  = ld ? cid_pkg::REG_SP : cid_pkg::REG_PC;
      dec_nxt.sub_op    = cid_pkg::SUB_ADD;
      dec_nxt.inst_type = ld ? cid_pkg::TYPE_ADR_SP : cid_pkg::TYPE_ADR_PC;
    end else if (top4 == 4'd11) begin
      if (h[15:8] == 8'hBE) begin
        dec_nxt.inst_type = cid_pkg::TYPE_BKPT;
      end else if (h[15:8] == 8'hBF) begin
        dec_nxt.inst_type = cid_pkg::TYPE_HINT;
      end else if (h[10:9] == 2'b10) begin
        dec_nxt.register_list = {ld & h[8], ~ld & h[8], 6'b0, h[7:0]};
        dec_nxt.is_load       = ld;
        dec_nxt.base_reg      = cid_pkg::REG_SP;
        dec_nxt.inst_type     = ld ? cid_pkg::TYPE_POP : cid_pkg::TYPE_PUSH;
      end else if (h[15:8] == 8'hB0) begin
        dec_nxt.immediate = {15'b0, h[6:0], 2'b0};
        dec_nxt.sub_op    = h[7] ? cid_pkg::SUB_SUB : cid_pkg::SUB_ADD;
        dec_nxt.dest_reg  = cid_pkg::REG_SP;
        dec_nxt.base_reg  = cid_pkg::REG_SP;
        dec_nxt.inst_type = cid_pkg::TYPE_ADD_SP + {5'b0, h[7]};
      end
    end else if (top4 == 4'd12) begin
      dec_nxt.base_reg      = {2'b0, h[10:8]};
      dec_nxt.register_list = {8'b0, h[7:0]};
      dec_nxt.is_load       = ld;
      dec_nxt.inst_type     = cid_pkg::TYPE_STMIA + {5'b0, ld};
    end else if (top4 == 4'd13) begin
      if (h[11:8] == cid_pkg::COND_NV) begin
        dec_nxt.inst_type = cid_pkg::TYPE_SVC;
        dec_nxt.immediate = {16'b0, h[7:0]};
      end else if (h[11:8] != cid_pkg::COND_AL) begin
        dec_nxt.inst_type = cid_pkg::TYPE_BCOND;
        dec_nxt.condition = h[11:8];
        dec_nxt.immediate = {{15{h[7]}}, h[7:0], 1'b0};
      end
    end else if (top5 == 5'h1C) begin
      dec_nxt.inst_type = cid_pkg::TYPE_B;
      dec_nxt.condition = cid_pkg::COND_AL;
      dec_nxt.immediate = {{12{h[10]}}, h[10:0], 1'b0};
    end else if (top4 == 4'd15) begin
      dec_nxt.inst_type = cid_pkg::TYPE_BL;
      dec_nxt.condition = cid_pkg::COND_AL;
      dec_nxt.sub_op    = cid_pkg::SUB_BL;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b0, out_dec_r};

`ifndef SYNTHESIS
  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_vld_r)
    else $error("accepted transfer not held in input register");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && advance |=> out_vld_r)
    else $error("decoded item not moved to result register");

  a_unknown_defaults: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dec_r.inst_type == cid_pkg::TYPE_UNKNOWN |->
      out_dec_r.dest_reg == cid_pkg::REG_NONE && out_dec_r.base_reg == cid_pkg::REG_NONE &&
      out_dec_r.register_list == 16'd0 && out_dec_r.immediate == 24'd0)
    else $error("unknown instruction with non-default fields");

  a_flags_forms: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dec_r.set_flags |->
      out_dec_r.inst_type >= cid_pkg::TYPE_ADD_REG &&
      out_dec_r.inst_type <= cid_pkg::TYPE_SUB_IMM8)
    else $error("set_flags on a form that does not set flags");
`endif

endmodule
`default_nettype wire
